// ----- src/interleave_string_checker_assert.svh -----
// ------------------------------------------------------------------------
// interleave string checker assertion macros
// concurrent checks clocked on clk and disabled while rst is high
// ------------------------------------------------------------------------
`ifndef INTERLEAVE_STRING_CHECKER_ASSERT_SVH
`define INTERLEAVE_STRING_CHECKER_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define ISC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define ISC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/isc_pkg.sv -----
// ------------------------------------------------------------------------
// isc_pkg
// sizes, codes and the microcode table of the interleave string checker
// ------------------------------------------------------------------------
package isc_pkg;

  localparam int ACTION_W          = 2;
  localparam int CHAR_W            = 8;
  localparam int MAX_PART_LEN      = 64;
  localparam int MAX_CANDIDATE_LEN = 128;

  // address and count widths
  localparam int PART_AW = (MAX_PART_LEN > 1) ? $clog2(MAX_PART_LEN) : 1;
  localparam int PART_CW = $clog2(MAX_PART_LEN + 1);
  localparam int CAND_AW = (MAX_CANDIDATE_LEN > 1) ? $clog2(MAX_CANDIDATE_LEN) : 1;
  localparam int CAND_CW = $clog2(MAX_CANDIDATE_LEN + 1);
  // width of candidate index sums i + j
  localparam int IDX_W   = (PART_CW + 1 > CAND_CW) ? PART_CW + 1 : CAND_CW;
  localparam int STEP_W  = 3;

  typedef enum logic [ACTION_W-1:0] {
    ACT_FIRST     = 2'd0,
    ACT_SECOND    = 2'd1,
    ACT_CANDIDATE = 2'd2,
    ACT_FINISH    = 2'd3
  } action_t;

  // microprogram step addresses
  typedef enum logic [STEP_W-1:0] {
    STEP_IDLE    = 3'd0,
    STEP_CHECK   = 3'd1,
    STEP_ROW_RD  = 3'd2,
    STEP_ROW_WR  = 3'd3,
    STEP_CELL_RD = 3'd4,
    STEP_CELL_WR = 3'd5,
    STEP_ROW_END = 3'd6,
    STEP_EMIT    = 3'd7
  } step_t;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NONE       = 3'd0,
    COND_NOT_FINISH = 3'd1,
    COND_BAD        = 3'd2,
    COND_N2_ZERO    = 3'd3,
    COND_J_NOT_LAST = 3'd4,
    COND_I_NOT_LAST = 3'd5,
    COND_OUT_BUSY   = 3'd6
  } cond_t;

  typedef struct packed {
    logic  take_load;  // load channel ready
    logic  clr_i;      // start row counter
    logic  rd_row;     // row start addresses instead of cell addresses
    logic  wr_row0;    // update column zero of the reach row
    logic  wr_cell;    // update one cell of the reach row
    logic  inc_i;      // next row
    logic  emit;       // post the verdict
    cond_t cond;
    step_t target;     // taken when cond holds, else fall through
  } ctrl_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w        = '0;
    w.cond   = COND_NONE;
    w.target = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        w.take_load = 1'b1;
        w.cond      = COND_NOT_FINISH;
        w.target    = STEP_IDLE;
      end
      STEP_CHECK: begin
        w.clr_i  = 1'b1;
        w.cond   = COND_BAD;
        w.target = STEP_EMIT;
      end
      STEP_ROW_RD: begin
        w.rd_row = 1'b1;
      end
      STEP_ROW_WR: begin
        w.wr_row0 = 1'b1;
        w.cond    = COND_N2_ZERO;
        w.target  = STEP_ROW_END;
      end
      STEP_CELL_RD: begin
        w.cond = COND_NONE;
      end
      STEP_CELL_WR: begin
        w.wr_cell = 1'b1;
        w.cond    = COND_J_NOT_LAST;
        w.target  = STEP_CELL_RD;
      end
      STEP_ROW_END: begin
        w.inc_i  = 1'b1;
        w.cond   = COND_I_NOT_LAST;
        w.target = STEP_ROW_RD;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond = COND_NONE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- src/isc_in_if.sv -----
// ------------------------------------------------------------------------
// isc_in_if
// load channel: action code and character byte
// ------------------------------------------------------------------------
interface isc_in_if;
  logic                        valid;
  logic                        ready;
  logic [isc_pkg::ACTION_W-1:0] action;
  logic [isc_pkg::CHAR_W-1:0]   char_value;

  modport source (output valid, output action, output char_value, input ready);
  modport sink   (input valid, input action, input char_value, output ready);
endinterface

// ----- src/isc_out_if.sv -----
// ------------------------------------------------------------------------
// isc_out_if
// verdict channel: interleaving result and status flags
// ------------------------------------------------------------------------
interface isc_out_if;
  logic valid;
  logic ready;
  logic is_interleaving;
  logic length_mismatch;
  logic overflowed;

  modport source (output valid, output is_interleaving, output length_mismatch,
                  output overflowed, input ready);
  modport sink   (input valid, input is_interleaving, input length_mismatch,
                  input overflowed, output ready);
endinterface

// ----- src/interleave_string_checker.sv -----
// ------------------------------------------------------------------------
// interleave_string_checker
// decides whether a candidate string interleaves two other strings
// ------------------------------------------------------------------------
//
//  channel  dir  payload                                   transfer moves
//  -------  ---  ----------------------------------------  ----------------
//  load     in   action, char_value                        one char or finish
//  result   out  is_interleaving, length_mismatch,         one verdict
//                overflowed
//
//  char loads are taken back to back, even while a posted verdict waits
//  a finish walks the grid with one-read-per-cycle buffers and reach row:
//    the check step, then per row 0 to n1 a row read, row write, a cell
//    read and write per column 1 to n2 and a row end, then emit
//    (n1, n2 the kept first and second lengths); a length mismatch or an
//    overflow skips to emit; load is not ready while a finish is being worked on
//  the verdict holds in its output register until the result transfer;
//    the emit step waits while the previous verdict is still pending
//  synchronous reset clears the step counter, counts, flag and output valid
//
`include "interleave_string_checker_assert.svh"

module interleave_string_checker (
  input  logic             clk,
  input  logic             rst,
  isc_in_if.sink           load,
  isc_out_if.source        result
);

  // sequencer state
  isc_pkg::step_t upc;
  isc_pkg::step_t upc_next;
  isc_pkg::ctrl_t ctrl;
  logic           take;

  // loaded lengths and overflow flag
  logic [isc_pkg::PART_CW-1:0] first_count;
  logic [isc_pkg::PART_CW-1:0] second_count;
  logic [isc_pkg::CAND_CW-1:0] candidate_count;
  logic                        overflow_seen;

  // string buffers and the rolling reach row
  logic [isc_pkg::CHAR_W-1:0] first_buffer     [isc_pkg::MAX_PART_LEN];
  logic [isc_pkg::CHAR_W-1:0] second_buffer    [isc_pkg::MAX_PART_LEN];
  logic [isc_pkg::CHAR_W-1:0] candidate_buffer [isc_pkg::MAX_CANDIDATE_LEN];
  logic                       reach_row        [isc_pkg::MAX_PART_LEN + 1];

  // registered read data
  logic [isc_pkg::CHAR_W-1:0] first_q;
  logic [isc_pkg::CHAR_W-1:0] second_q;
  logic [isc_pkg::CHAR_W-1:0] cand_q;
  logic                       row_q;

  // walk registers: row i, column j, current first char, left neighbor
  logic [isc_pkg::PART_CW-1:0] i;
  logic [isc_pkg::PART_CW-1:0] j;
  logic [isc_pkg::CHAR_W-1:0]  a;
  logic                        prev;

  // output register
  logic out_valid;
  logic out_is_interleaving;
  logic out_length_mismatch;
  logic out_overflowed;

  // handshake and datapath helpers
  logic                        load_fire;
  logic                        is_finish;
  logic                        out_busy;
  logic                        emit_go;
  logic                        mismatch;
  logic [isc_pkg::PART_CW-1:0] i_m1;
  logic [isc_pkg::PART_CW-1:0] j_m1;
  logic [isc_pkg::IDX_W-1:0]   cand_cell_idx;
  logic [isc_pkg::IDX_W-1:0]   cand_row_idx;
  logic [isc_pkg::PART_AW-1:0] first_rd_addr;
  logic [isc_pkg::PART_AW-1:0] second_rd_addr;
  logic [isc_pkg::CAND_AW-1:0] cand_rd_addr;
  logic [isc_pkg::PART_CW-1:0] row_addr;
  logic                        row0_val;
  logic                        cell_val;
  logic                        first_room;
  logic                        second_room;
  logic                        cand_room;

  // ----------------------------------------------------------------------
  // control word decode and handshakes
  // ----------------------------------------------------------------------
  always_comb begin
    ctrl       = isc_pkg::ucode(upc);
    load.ready = ctrl.take_load;
  end

  assign load_fire = load.valid && load.ready;
  assign is_finish = (load.action == isc_pkg::ACT_FINISH);
  assign out_busy  = out_valid && !result.ready;
  assign emit_go   = ctrl.emit && !out_busy;

  // candidate length against the sum of the kept part lengths
  assign mismatch = (isc_pkg::IDX_W'(candidate_count) !=
                     isc_pkg::IDX_W'(first_count) + isc_pkg::IDX_W'(second_count));

  assign first_room  = (first_count < isc_pkg::PART_CW'(isc_pkg::MAX_PART_LEN));
  assign second_room = (second_count < isc_pkg::PART_CW'(isc_pkg::MAX_PART_LEN));
  assign cand_room   = (candidate_count < isc_pkg::CAND_CW'(isc_pkg::MAX_CANDIDATE_LEN));

  // ----------------------------------------------------------------------
  // next step: jump to the target when the condition holds, else fall through
  // ----------------------------------------------------------------------
  always_comb begin
    case (ctrl.cond)
      isc_pkg::COND_NONE:       take = 1'b0;
      isc_pkg::COND_NOT_FINISH: take = !(load_fire && is_finish);
      isc_pkg::COND_BAD:        take = mismatch || overflow_seen;
      isc_pkg::COND_N2_ZERO:    take = (second_count == '0);
      isc_pkg::COND_J_NOT_LAST: take = (j != second_count);
      isc_pkg::COND_I_NOT_LAST: take = (i != first_count);
      isc_pkg::COND_OUT_BUSY:   take = out_busy;
      default:                  take = 1'b0;
    endcase
    if (take) begin
      upc_next = ctrl.target;
    end else begin
      upc_next = isc_pkg::step_t'(upc + 1'b1);
    end
  end

  // ----------------------------------------------------------------------
  // read addresses
  // row start reads first[i-1], candidate[i-1] and reach_row[0];
  // a cell reads candidate[i+j-1], second[j-1] and reach_row[j]
  // ----------------------------------------------------------------------
  assign i_m1           = i - 1'b1;
  assign j_m1           = j - 1'b1;
  assign cand_row_idx   = isc_pkg::IDX_W'(i_m1);
  assign cand_cell_idx  = isc_pkg::IDX_W'(i) + isc_pkg::IDX_W'(j) - 1'b1;
  assign first_rd_addr  = i_m1[isc_pkg::PART_AW-1:0];
  assign second_rd_addr = j_m1[isc_pkg::PART_AW-1:0];
  assign cand_rd_addr   = ctrl.rd_row ? cand_row_idx[isc_pkg::CAND_AW-1:0]
                                      : cand_cell_idx[isc_pkg::CAND_AW-1:0];
  assign row_addr       = (ctrl.rd_row || ctrl.wr_row0) ? '0 : j;

  // ----------------------------------------------------------------------
  // recurrence: column zero only follows the first string, a cell takes
  // either the first-string char from above or the second-string char
  // from the left; row zero has nothing above
  // ----------------------------------------------------------------------
  assign row0_val = (i == '0) ? 1'b1 : (row_q && (first_q == cand_q));
  assign cell_val = ((i != '0) && row_q && (a == cand_q)) ||
                    (prev && (second_q == cand_q));

  // ----------------------------------------------------------------------
  // buffer memories
  // ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (load_fire && (load.action == isc_pkg::ACT_FIRST) && first_room) begin
      first_buffer[first_count[isc_pkg::PART_AW-1:0]] <= load.char_value;
    end
    first_q <= first_buffer[first_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_fire && (load.action == isc_pkg::ACT_SECOND) && second_room) begin
      second_buffer[second_count[isc_pkg::PART_AW-1:0]] <= load.char_value;
    end
    second_q <= second_buffer[second_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load_fire && (load.action == isc_pkg::ACT_CANDIDATE) && cand_room) begin
      candidate_buffer[candidate_count[isc_pkg::CAND_AW-1:0]] <= load.char_value;
    end
    cand_q <= candidate_buffer[cand_rd_addr];
  end

  // reach row: one write and one read per cycle at the same address
  always_ff @(posedge clk) begin
    if (ctrl.wr_row0) begin
      reach_row[row_addr] <= row0_val;
    end else if (ctrl.wr_cell) begin
      reach_row[row_addr] <= cell_val;
    end
    row_q <= reach_row[row_addr];
  end

  // ----------------------------------------------------------------------
  // control state: step counter, counts, overflow, output valid
  // ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      upc             <= isc_pkg::STEP_IDLE;
      first_count     <= '0;
      second_count    <= '0;
      candidate_count <= '0;
      overflow_seen   <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      upc <= upc_next;
      if (load_fire) begin
        case (load.action)
          isc_pkg::ACT_FIRST: begin
            if (first_room) begin
              first_count <= first_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          isc_pkg::ACT_SECOND: begin
            if (second_room) begin
              second_count <= second_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          isc_pkg::ACT_CANDIDATE: begin
            if (cand_room) begin
              candidate_count <= candidate_count + 1'b1;
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          default: begin
            overflow_seen <= overflow_seen;
          end
        endcase
      end
      // verdict posted: start over with empty strings
      if (emit_go) begin
        first_count     <= '0;
        second_count    <= '0;
        candidate_count <= '0;
        overflow_seen   <= 1'b0;
        out_valid       <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------------
  // walk registers and verdict payload
  // ----------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctrl.clr_i) begin
      i <= '0;
    end else if (ctrl.inc_i) begin
      i <= i + 1'b1;
    end
    if (ctrl.wr_row0) begin
      j    <= isc_pkg::PART_CW'(1);
      prev <= row0_val;
      a    <= first_q;
    end else if (ctrl.wr_cell) begin
      j    <= j + 1'b1;
      prev <= cell_val;
    end
    if (emit_go) begin
      out_is_interleaving <= prev && !mismatch && !overflow_seen;
      out_length_mismatch <= mismatch;
      out_overflowed      <= overflow_seen;
    end
  end

  assign result.valid           = out_valid;
  assign result.is_interleaving = out_is_interleaving;
  assign result.length_mismatch = out_length_mismatch;
  assign result.overflowed      = out_overflowed;

  // ----------------------------------------------------------------------
  // assertions
  // ----------------------------------------------------------------------
  `ISC_ASSERT_NEXT(a_emit_posts, emit_go, result.valid && (upc == isc_pkg::STEP_IDLE), "verdict not posted after emit")
  `ISC_ASSERT_NEXT(a_emit_clears, emit_go, (first_count == '0) && (second_count == '0) && (candidate_count == '0) && !overflow_seen, "lengths not cleared after verdict")
  `ISC_ASSERT_NOW(a_cell_in_range, upc == isc_pkg::STEP_CELL_WR, (j != '0) && (j <= second_count), "cell column outside the second string")
  `ISC_ASSERT_NOW(a_row_in_range, upc == isc_pkg::STEP_ROW_END, i <= first_count, "row index beyond the first string")

endmodule

// ----- verif/interleave_string_checker_monitor.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// interleave_string_checker_monitor
// watches the load and result channels, keeps its own copy of the three
// string buffers, predicts each verdict and compares it on transfer
// ------------------------------------------------------------------------
module interleave_string_checker_monitor
  import isc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  isc_in_if           load,
  isc_out_if          result,
  output int unsigned fail_count,
  output int unsigned pending
);

  typedef struct packed {
    logic is_interleaving;
    logic length_mismatch;
    logic overflowed;
  } verdict_t;

  logic [CHAR_W-1:0] first_str  [MAX_PART_LEN];
  logic [CHAR_W-1:0] second_str [MAX_PART_LEN];
  logic [CHAR_W-1:0] cand_str   [MAX_CANDIDATE_LEN];
  int unsigned       first_len;
  int unsigned       second_len;
  int unsigned       cand_len;
  bit                dropped;
  verdict_t          verdict_q [$];

  // rolling-row reachability over the first x second grid
  function automatic logic walk_grid();
    bit                reach [MAX_PART_LEN+1];
    logic [CHAR_W-1:0] a;
    logic [CHAR_W-1:0] c;
    bit                from_first;
    bit                from_second;
    reach[0] = 1'b1;
    for (int j = 1; j <= second_len; j++)
      reach[j] = reach[j-1] && (second_str[j-1] == cand_str[j-1]);
    for (int i = 1; i <= first_len; i++) begin
      a = first_str[i-1];
      reach[0] = reach[0] && (a == cand_str[i-1]);
      for (int j = 1; j <= second_len; j++) begin
        c           = cand_str[i+j-1];
        from_first  = reach[j] && (a == c);
        from_second = reach[j-1] && (second_str[j-1] == c);
        reach[j]    = from_first || from_second;
      end
    end
    return reach[second_len];
  endfunction

  function automatic void take_load(action_t act, logic [CHAR_W-1:0] ch);
    verdict_t v;
    case (act)
      ACT_FIRST: begin
        if (first_len < MAX_PART_LEN) begin
          first_str[first_len] = ch;
          first_len++;
        end else dropped = 1'b1;
      end
      ACT_SECOND: begin
        if (second_len < MAX_PART_LEN) begin
          second_str[second_len] = ch;
          second_len++;
        end else dropped = 1'b1;
      end
      ACT_CANDIDATE: begin
        if (cand_len < MAX_CANDIDATE_LEN) begin
          cand_str[cand_len] = ch;
          cand_len++;
        end else dropped = 1'b1;
      end
      default: begin
        v.length_mismatch = (cand_len != first_len + second_len);
        v.overflowed      = dropped;
        v.is_interleaving = (!v.length_mismatch && !dropped) ? walk_grid() : 1'b0;
        verdict_q.push_back(v);
        first_len  = 0;
        second_len = 0;
        cand_len   = 0;
        dropped    = 1'b0;
      end
    endcase
  endfunction

  initial fail_count = 0;

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      first_len  = 0;
      second_len = 0;
      cand_len   = 0;
      dropped    = 1'b0;
      verdict_q.delete();
    end else begin
      if (load.valid && load.ready)
        take_load(action_t'(load.action), load.char_value);
      if (result.valid && result.ready) begin
        if (verdict_q.size() == 0) begin
          $error("result transfer with no verdict expected");
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (result.is_interleaving !== want.is_interleaving) begin
            $error("is_interleaving: expected %0d, actual %0d",
                   want.is_interleaving, result.is_interleaving);
            fail_count++;
          end
          if (result.length_mismatch !== want.length_mismatch) begin
            $error("length_mismatch: expected %0d, actual %0d",
                   want.length_mismatch, result.length_mismatch);
            fail_count++;
          end
          if (result.overflowed !== want.overflowed) begin
            $error("overflowed: expected %0d, actual %0d",
                   want.overflowed, result.overflowed);
            fail_count++;
          end
        end
      end
    end
    pending = verdict_q.size();
  end

endmodule

// ----- verif/interleave_string_checker_test.sv -----
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// interleave_string_checker_test
// drives string loads and finish commands into the interleave checker,
// with random gaps on the load side and random stalls on the verdict side;
// a separate monitor predicts every verdict and counts mismatches
// ------------------------------------------------------------------------
module interleave_string_checker_test;
  import isc_pkg::*;

  // total load-side items to drive, directed part included
  localparam int unsigned ITEM_TARGET = 1700;
  // far above the slowest legal run, including a few full 64 x 64 grids
  localparam int unsigned CYCLE_LIMIT = 3_000_000;

  logic        clk;
  logic        rst;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  bit          sink_calm;

  isc_in_if  load_ch ();
  isc_out_if result_ch ();

  interleave_string_checker dut (
    .clk    (clk),
    .rst    (rst),
    .load   (load_ch),
    .result (result_ch)
  );

  interleave_string_checker_monitor monitor (
    .clk        (clk),
    .rst        (rst),
    .load       (load_ch),
    .result     (result_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: a hang ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one load transfer; valid stays high across back-to-back items
  task automatic send_item(input action_t act, input logic [CHAR_W-1:0] ch,
                           input int gap);
    if (gap > 0) begin
      load_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    load_ch.valid      <= 1'b1;
    load_ch.action     <= act;
    load_ch.char_value <= ch;
    @(posedge clk);
    while (!load_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic int draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // character from a small window of the byte range, wrapping at 255
  function automatic logic [CHAR_W-1:0] pick_char(int base, int span);
    return CHAR_W'((base + $urandom_range(0, span - 1)) & 8'hFF);
  endfunction

  // one string set: build two parts, a candidate from a random merge
  // (kept or damaged at about even odds, or padded past its buffer), load
  // them in a random mixed order, then finish
  task automatic run_sequence();
    logic [CHAR_W-1:0] part_a [$];
    logic [CHAR_W-1:0] part_b [$];
    logic [CHAR_W-1:0] merged [$];
    logic [CHAR_W-1:0] held;
    int                n1, n2, kind, base, span, ia, ib, pa, pb, pc;
    int                pick, damage, pos, stream;
    bit                calm;

    kind = $urandom_range(0, 99);
    if (kind < 3) begin
      // full-size grid
      n1 = MAX_PART_LEN;
      n2 = MAX_PART_LEN;
    end else if (kind < 6) begin
      n1 = $urandom_range(30, MAX_PART_LEN);
      n2 = $urandom_range(30, MAX_PART_LEN);
    end else if (kind < 9) begin
      // one part runs past its buffer
      n1 = $urandom_range(0, 1) ? MAX_PART_LEN + $urandom_range(1, 2) : $urandom_range(0, 4);
      n2 = (n1 > MAX_PART_LEN) ? $urandom_range(0, 4) : MAX_PART_LEN + $urandom_range(1, 2);
    end else begin
      n1 = $urandom_range(0, 6);
      n2 = $urandom_range(0, 6);
    end

    // narrow alphabets make real interleavings likely; sometimes full bytes
    span = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 3);
    base = $urandom_range(0, 255);
    repeat (n1) part_a.push_back(pick_char(base, span));
    repeat (n2) part_b.push_back(pick_char(base, span));

    ia = 0;
    ib = 0;
    while (ia < n1 || ib < n2) begin
      if (ib >= n2 || (ia < n1 && $urandom_range(0, 1))) begin
        merged.push_back(part_a[ia]);
        ia++;
      end else begin
        merged.push_back(part_b[ib]);
        ib++;
      end
    end

    if (kind == 9 || kind == 10) begin
      // candidate runs past its buffer
      while (merged.size() < MAX_CANDIDATE_LEN + 1 + $urandom_range(0, 2))
        merged.push_back(CHAR_W'($urandom_range(0, 255)));
    end else begin
      damage = $urandom_range(0, 9);
      if (damage >= 5 && damage < 8 && merged.size() > 0) begin
        pos = $urandom_range(0, merged.size() - 1);
        merged[pos] = pick_char(base, span);
      end else if (damage == 8 && merged.size() > 1) begin
        pos          = $urandom_range(0, merged.size() - 2);
        held         = merged[pos];
        merged[pos]  = merged[pos+1];
        merged[pos+1] = held;
      end else if (damage == 9) begin
        // off-by-one length
        if (merged.size() > 0 && $urandom_range(0, 1))
          merged.delete($urandom_range(0, merged.size() - 1));
        else
          merged.push_back(pick_char(base, span));
      end
    end

    calm = ($urandom_range(0, 3) == 0);
    pa = 0;
    pb = 0;
    pc = 0;
    while (pa < part_a.size() || pb < part_b.size() || pc < merged.size()) begin
      // rare stray item, finish included, to break the set
      if ($urandom_range(0, 59) == 0)
        send_item(action_t'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                  draw_gap(calm));
      pick = $urandom_range(0, 2);
      for (int k = 0; k < 3; k++) begin
        stream = (pick + k) % 3;
        if (stream == 0 && pa < part_a.size()) begin
          send_item(ACT_FIRST, part_a[pa], draw_gap(calm));
          pa++;
          break;
        end
        if (stream == 1 && pb < part_b.size()) begin
          send_item(ACT_SECOND, part_b[pb], draw_gap(calm));
          pb++;
          break;
        end
        if (stream == 2 && pc < merged.size()) begin
          send_item(ACT_CANDIDATE, merged[pc], draw_gap(calm));
          pc++;
          break;
        end
      end
    end
    // char_value is a don't-care on finish, so make it random
    send_item(ACT_FINISH, CHAR_W'($urandom_range(0, 255)), draw_gap(calm));
  endtask

  // verdict side: random stall before each result, with calm stretches
  initial begin
    int gap;
    result_ch.ready = 1'b0;
    sink_calm       = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) sink_calm = !sink_calm;
      gap = sink_calm ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!result_ch.valid) @(posedge clk);
    end
  end

  // load side stimulus and final verdict
  initial begin
    rst                = 1'b1;
    load_ch.valid      = 1'b0;
    load_ch.action     = ACT_FIRST;
    load_ch.char_value = '0;
    items_sent         = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: three empty strings interleave trivially
    send_item(ACT_FINISH, 8'h00, 0);
    // byte extremes, candidate takes second first
    send_item(ACT_FIRST, 8'h00, 0);
    send_item(ACT_SECOND, 8'hFF, 0);
    send_item(ACT_CANDIDATE, 8'hFF, 1);
    send_item(ACT_CANDIDATE, 8'h00, 0);
    send_item(ACT_FINISH, 8'hFF, 2);
    // equal lengths but wrong character
    send_item(ACT_FIRST, 8'h41, 0);
    send_item(ACT_CANDIDATE, 8'h42, 0);
    send_item(ACT_FINISH, 8'h00, 0);
    // candidate longer than both parts together
    send_item(ACT_CANDIDATE, 8'h55, 3);
    send_item(ACT_FINISH, 8'hAA, 0);
    // only the second string
    send_item(ACT_SECOND, 8'h12, 0);
    send_item(ACT_CANDIDATE, 8'h12, 0);
    send_item(ACT_FINISH, 8'h00, 5);
    // "ab" with "ba" gives "abba"; order of loads mixed
    send_item(ACT_FIRST, 8'h61, 0);
    send_item(ACT_CANDIDATE, 8'h61, 0);
    send_item(ACT_SECOND, 8'h62, 0);
    send_item(ACT_FIRST, 8'h62, 0);
    send_item(ACT_CANDIDATE, 8'h62, 0);
    send_item(ACT_SECOND, 8'h61, 0);
    send_item(ACT_CANDIDATE, 8'h62, 0);
    send_item(ACT_CANDIDATE, 8'h61, 0);
    send_item(ACT_FINISH, 8'h7F, 0);

    while (items_sent < ITEM_TARGET) run_sequence();
    load_ch.valid <= 1'b0;

    // let the monitor record the last finish, drain outstanding verdicts,
    // then a short quiet tail
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/isc_pkg.sv
src/isc_in_if.sv
src/isc_out_if.sv
src/interleave_string_checker.sv
verif/interleave_string_checker_monitor.sv
verif/interleave_string_checker_test.sv
